// File: hw/rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants of the console cursor engine
// Character codes, result actions, register indexes and the step record.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_LINE  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 8'd3;

	localparam logic [11:0] RST_SCREEN_WIDTH    = 12'd1024;
	localparam logic [11:0] RST_SCREEN_HEIGHT   = 12'd768;
	localparam logic [14:0] RST_BYTES_PER_LINE  = 15'd3072;
	localparam logic [2:0]  RST_BYTES_PER_PIXEL = 3'd3;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_UP  = 8'h01;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic [1:0] ACT_MOVE  = 2'd0;
	localparam logic [1:0] ACT_DRAW  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic signed [15:0] LEFT_MARGIN = 16'sd4;
	localparam logic signed [15:0] TOP_MARGIN  = 16'sd28;
	localparam logic signed [15:0] LINE_HEIGHT = 16'sd16;
	localparam logic signed [15:0] CELL_WIDTH  = 16'sd8;
	localparam logic signed [16:0] TAB_STOP    = 17'sd64;

	typedef logic signed [15:0] coord_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  glyph;
		logic [15:0] cell_x;
		logic [15:0] cell_y;
		coord_t      cur_x;
		coord_t      cur_y;
	} step_t;

endpackage

// File: hw/rtl/tcc_ifs.sv
// ----------------------------------------------------------------------------
// tcc_ifs: channel interfaces of the console cursor engine
// Character input, result output and register write channels.
// ----------------------------------------------------------------------------
interface tcc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

interface tcc_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  glyph;
	logic [11:0] cell_x;
	logic [11:0] cell_y;
	logic [25:0] pixel_offset;
	logic [11:0] cursor_col;
	logic [11:0] cursor_row;

	modport source (output valid, output action, output glyph, output cell_x,
		output cell_y, output pixel_offset, output cursor_col, output cursor_row,
		input ready);
	modport sink (input valid, input action, input glyph, input cell_x,
		input cell_y, input pixel_offset, input cursor_col, input cursor_row,
		output ready);
endinterface

interface tcc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tcc_pkg::CFG_IDX_W-1:0]  index;
	logic [tcc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/text_console_cursor_engine_unit.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit: pixel text console cursor engine
// Keeps the console cursor and emits one draw/move/clear result per character.
// ----------------------------------------------------------------------------
// Usage:
//   char_in  takes one character byte per item; res_out gives one result item
//   per character, in order: action, glyph, cell position, framebuffer byte
//   offset and the cursor after the character.
//   cfg writes screen_width (0), screen_height (1), bytes_per_line (2) and
//   bytes_per_pixel (3); other indexes are dropped. cfg is always ready, and the
//   user must see that cfg is written only while no character is in flight;
//   the block itself does not enforce it. An accepted character enters stage
//   one with the cursor updated in the same cycle, and the byte offset
//   multiply then fills the output register from stage one.
//   Throughput is one character per cycle while the receiver is ready; the
//   cursor register loop goes through combinational logic only.
//   A stalled receiver holds the output register; one more item still enters
//   stage one, then char_in.ready drops until the output drains.
//   Reset sets the cursor to (4, 28), loads the default registers and
//   empties both stages.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit (
	input  logic         clk,
	input  logic         arst_n,
	tcc_cfg_if.sink      cfg,
	tcc_char_if.sink     char_in,
	tcc_res_if.source    res_out
);

	logic [11:0]     scr_w_q;
	logic [11:0]     scr_h_q;
	logic [14:0]     bpl_q;
	logic [2:0]      bpp_q;
	tcc_pkg::coord_t cur_x_q;
	tcc_pkg::coord_t cur_y_q;

	tcc_pkg::step_t  step_next;
	tcc_pkg::step_t  step_s1;
	logic            valid_s1;
	logic            valid_s2;
	logic            ready_s1;
	logic            ready_s2;
	logic            accept;

	logic [1:0]      action_s2;
	logic [7:0]      glyph_s2;
	logic [11:0]     cell_x_s2;
	logic [11:0]     cell_y_s2;
	logic [25:0]     offset_s2;
	logic [11:0]     col_s2;
	logic [11:0]     row_s2;

	logic [30:0]     prod_y;
	logic [18:0]     prod_x;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= tcc_pkg::RST_SCREEN_WIDTH;
			scr_h_q <= tcc_pkg::RST_SCREEN_HEIGHT;
			bpl_q   <= tcc_pkg::RST_BYTES_PER_LINE;
			bpp_q   <= tcc_pkg::RST_BYTES_PER_PIXEL;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tcc_pkg::REG_SCREEN_WIDTH:    scr_w_q <= cfg.data[11:0];
				tcc_pkg::REG_SCREEN_HEIGHT:   scr_h_q <= cfg.data[11:0];
				tcc_pkg::REG_BYTES_PER_LINE:  bpl_q   <= cfg.data[14:0];
				tcc_pkg::REG_BYTES_PER_PIXEL: bpp_q   <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	tcc_cursor_next u_next (
		.char_code     (char_in.char_code),
		.cur_x         (cur_x_q),
		.cur_y         (cur_y_q),
		.screen_width  (scr_w_q),
		.screen_height (scr_h_q),
		.step          (step_next)
	);

	assign ready_s2      = !valid_s2 || res_out.ready;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign char_in.ready = ready_s1;
	assign accept        = char_in.valid && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= tcc_pkg::LEFT_MARGIN;
			cur_y_q  <= tcc_pkg::TOP_MARGIN;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				cur_x_q <= step_next.cur_x;
				cur_y_q <= step_next.cur_y;
			end
			if (ready_s1) begin
				valid_s1 <= char_in.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1 <= step_next;
		end
	end

	assign prod_y = {15'd0, step_s1.cell_y} * {16'd0, bpl_q};
	assign prod_x = {3'd0, step_s1.cell_x} * {16'd0, bpp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			action_s2 <= step_s1.action;
			glyph_s2  <= step_s1.glyph;
			cell_x_s2 <= step_s1.cell_x[11:0];
			cell_y_s2 <= step_s1.cell_y[11:0];
			offset_s2 <= prod_y[25:0] + {7'd0, prod_x};
			col_s2    <= step_s1.cur_x[11:0];
			row_s2    <= step_s1.cur_y[11:0];
		end
	end

	assign res_out.valid        = valid_s2;
	assign res_out.action       = action_s2;
	assign res_out.glyph        = glyph_s2;
	assign res_out.cell_x       = cell_x_s2;
	assign res_out.cell_y       = cell_y_s2;
	assign res_out.pixel_offset = offset_s2;
	assign res_out.cursor_col   = col_s2;
	assign res_out.cursor_row   = row_s2;

endmodule

// File: hw/rtl/tcc_cursor_next.sv
// ----------------------------------------------------------------------------
// tcc_cursor_next: cursor update for one character
// Applies the control code or glyph advance, horizontal wrap and vertical clamp.
// ----------------------------------------------------------------------------
module tcc_cursor_next (
	input  logic [7:0]       char_code,
	input  tcc_pkg::coord_t  cur_x,
	input  tcc_pkg::coord_t  cur_y,
	input  logic [11:0]      screen_width,
	input  logic [11:0]      screen_height,
	output tcc_pkg::step_t   step
);

	always_comb begin
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [16:0] d;
		logic signed [16:0] rem;
		logic signed [16:0] tab_x;
		logic signed [17:0] room;
		logic signed [15:0] thr;
		logic signed [15:0] wm8;
		logic signed [16:0] ylim;
		logic signed [16:0] y17;

		x = cur_x;
		y = cur_y;
		step.action = tcc_pkg::ACT_MOVE;
		step.glyph  = 8'd0;
		step.cell_x = 16'd0;
		step.cell_y = 16'd0;
		d     = {cur_x[15], cur_x} - 17'sd4;
		rem   = (d[16] && d[5:0] != 6'd0) ? ({11'd0, d[5:0]} - tcc_pkg::TAB_STOP)
			: {11'd0, d[5:0]};
		tab_x = {cur_x[15], cur_x} - rem + tcc_pkg::TAB_STOP;
		room  = 18'sd0;
		thr   = {4'd0, screen_width} - 16'd4;
		wm8   = {4'd0, screen_width} - 16'd8;
		ylim  = {5'd0, screen_height} - 17'sd16;
		y17   = 17'sd0;

		if (char_code != tcc_pkg::CH_NUL) begin
			unique case (char_code)
				tcc_pkg::CH_CR: x = tcc_pkg::LEFT_MARGIN;
				tcc_pkg::CH_LF: y = y + tcc_pkg::LINE_HEIGHT;
				tcc_pkg::CH_TAB: begin
					x    = tab_x[15:0];
					room = {6'd0, screen_width} - {{2{x[15]}}, x};
					if (room < 18'sd64) begin
						x = tcc_pkg::LEFT_MARGIN;
						y = y + tcc_pkg::LINE_HEIGHT;
					end
				end
				tcc_pkg::CH_BS: x = x - tcc_pkg::CELL_WIDTH;
				tcc_pkg::CH_FF: begin
					x = tcc_pkg::LEFT_MARGIN;
					y = tcc_pkg::TOP_MARGIN;
					step.action = tcc_pkg::ACT_CLEAR;
				end
				tcc_pkg::CH_UP: y = y - tcc_pkg::LINE_HEIGHT;
				default: begin
					step.action = tcc_pkg::ACT_DRAW;
					step.glyph  = char_code;
					step.cell_x = cur_x;
					step.cell_y = cur_y;
					x = x + tcc_pkg::CELL_WIDTH;
				end
			endcase

			if (x >= thr) begin
				x = x - wm8;
				y = y + tcc_pkg::LINE_HEIGHT;
			end else if (x < tcc_pkg::LEFT_MARGIN) begin
				x = x + wm8;
				y = y - tcc_pkg::LINE_HEIGHT;
			end

			y17 = {y[15], y};
			if (y < tcc_pkg::TOP_MARGIN) begin
				y = tcc_pkg::TOP_MARGIN;
			end else if (y17 > ylim) begin
				y = y - tcc_pkg::LINE_HEIGHT;
			end
		end

		step.cur_x = x;
		step.cur_y = y;
	end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the text console cursor engine
// Drives character items and register writes into the block and checks every
// result item against a cycle-free model of the cursor rules, with random
// gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;
	import tcc_pkg::*;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  glyph;
		logic [11:0] cell_x;
		logic [11:0] cell_y;
		logic [25:0] pixel_offset;
		logic [11:0] cursor_col;
		logic [11:0] cursor_row;
	} cell_report_t;

	localparam logic [7:0] OPENING_TEXT [20] = '{
		8'h41, 8'hFF, 8'h80, 8'h7F, CH_NUL, CH_CR, CH_BS, CH_UP, CH_LF, CH_TAB,
		CH_TAB, 8'h20, CH_FF, CH_LF, CH_UP, 8'h02, 8'h0B, 8'h0E, 8'h1B, CH_CR
	};
	localparam logic [7:0] NARROW_TEXT [5] = '{CH_FF, CH_BS, 8'h78, CH_TAB, CH_LF};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tcc_char_if char_bus ();
	tcc_res_if  res_bus ();
	tcc_cfg_if  cfg_bus ();

	text_console_cursor_engine_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.char_in (char_bus),
		.res_out (res_bus)
	);

	coord_t       cur_x;
	coord_t       cur_y;
	logic [11:0]  scr_w;
	logic [11:0]  scr_h;
	logic [14:0]  line_stride;
	logic [2:0]   pix_bytes;

	cell_report_t expected_cells [$];
	logic [7:0]   char_backlog [$];

	logic char_acc = 1'b0;
	int   send_gap = 0;
	int   recv_hold = 0;
	bit   send_gaps_on = 1'b1;
	bit   recv_stalls_on = 1'b1;
	int   holds_asked = 0;
	int   holds_served = 0;
	int   mismatch_count = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int to_coord(int v);
		return int'(shortint'(v));
	endfunction

	function automatic int idle_span();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic string describe(cell_report_t r);
		return $sformatf("act=%0d glyph=%02h cell=(%0d,%0d) offs=%07h cur=(%0d,%0d)",
			r.action, r.glyph, r.cell_x, r.cell_y, r.pixel_offset, r.cursor_col,
			r.cursor_row);
	endfunction

	function automatic cell_report_t advance_cursor(logic [7:0] ch);
		cell_report_t r;
		int           x;
		int           y;
		int           w;
		int           h;
		logic [15:0]  ux;
		logic [15:0]  uy;
		logic [63:0]  offs;
		r = '0;
		x = int'(cur_x);
		y = int'(cur_y);
		w = int'(scr_w);
		h = int'(scr_h);
		if (ch != CH_NUL) begin
			case (ch)
				CH_CR: x = int'(LEFT_MARGIN);
				CH_LF: y = to_coord(y + int'(LINE_HEIGHT));
				CH_TAB: begin
					x = to_coord(x - (x - int'(LEFT_MARGIN)) % int'(TAB_STOP)
						+ int'(TAB_STOP));
					if (w - x < int'(TAB_STOP)) begin
						x = int'(LEFT_MARGIN);
						y = to_coord(y + int'(LINE_HEIGHT));
					end
				end
				CH_BS: x = to_coord(x - int'(CELL_WIDTH));
				CH_FF: begin
					x = int'(LEFT_MARGIN);
					y = int'(TOP_MARGIN);
					r.action = ACT_CLEAR;
				end
				CH_UP: y = to_coord(y - int'(LINE_HEIGHT));
				default: begin
					ux = x[15:0];
					uy = y[15:0];
					offs = 64'(uy) * 64'(line_stride) + 64'(ux) * 64'(pix_bytes);
					r.action = ACT_DRAW;
					r.glyph = ch;
					r.cell_x = ux[11:0];
					r.cell_y = uy[11:0];
					r.pixel_offset = offs[25:0];
					x = to_coord(x + int'(CELL_WIDTH));
				end
			endcase
			if (x >= to_coord(w - 4)) begin
				x = to_coord(x - (w - 8));
				y = to_coord(y + int'(LINE_HEIGHT));
			end else if (x < int'(LEFT_MARGIN)) begin
				x = to_coord(x + (w - 8));
				y = to_coord(y - int'(LINE_HEIGHT));
			end
			if (y < int'(TOP_MARGIN))
				y = int'(TOP_MARGIN);
			else if (y > h - int'(LINE_HEIGHT))
				y = to_coord(y - int'(LINE_HEIGHT));
			cur_x = x[15:0];
			cur_y = y[15:0];
		end
		r.cursor_col = cur_x[11:0];
		r.cursor_row = cur_y[11:0];
		return r;
	endfunction

	always @(posedge clk) begin : watch_results
		cell_report_t got;
		cell_report_t want;
		char_acc <= char_bus.valid && char_bus.ready;
		if (arst_n && char_bus.valid && char_bus.ready)
			expected_cells.push_back(advance_cursor(char_bus.char_code));
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got = {res_bus.action, res_bus.glyph, res_bus.cell_x, res_bus.cell_y,
				res_bus.pixel_offset, res_bus.cursor_col, res_bus.cursor_row};
			if (expected_cells.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected item: %s", describe(got));
				mismatch_count++;
			end else begin
				want = expected_cells.pop_front();
				if (got.action !== want.action || got.glyph !== want.glyph
						|| got.cell_x !== want.cell_x || got.cell_y !== want.cell_y
						|| got.pixel_offset !== want.pixel_offset
						|| got.cursor_col !== want.cursor_col
						|| got.cursor_row !== want.cursor_row) begin
					if (mismatch_count < 10) begin
						$display("mismatch expected: %s", describe(want));
						$display("mismatch actual:   %s", describe(got));
					end
					mismatch_count++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!char_bus.valid || char_acc) begin
			if (send_gap > 0) begin
				send_gap--;
				char_bus.valid <= 1'b0;
			end else if (char_backlog.size() > 0) begin
				char_bus.char_code <= char_backlog.pop_front();
				char_bus.valid <= 1'b1;
				send_gap = (send_gaps_on && $urandom_range(0, 99) < 30) ? idle_span() : 0;
			end else
				char_bus.valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold--;
			res_bus.ready <= 1'b0;
		end else if (holds_served != holds_asked) begin
			holds_served++;
			recv_hold = 199;
			res_bus.ready <= 1'b0;
		end else if (recv_stalls_on && $urandom_range(0, 99) < 20) begin
			recv_hold = idle_span() - 1;
			res_bus.ready <= 1'b0;
		end else
			res_bus.ready <= 1'b1;
	end

	task automatic wait_drained();
		while (char_backlog.size() != 0 || char_bus.valid || expected_cells.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		case (idx)
			REG_SCREEN_WIDTH:    scr_w = value[11:0];
			REG_SCREEN_HEIGHT:   scr_h = value[11:0];
			REG_BYTES_PER_LINE:  line_stride = value[14:0];
			REG_BYTES_PER_PIXEL: pix_bytes = value[2:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic set_screen(logic [11:0] w, logic [11:0] h, logic [14:0] bpl,
			logic [2:0] bpp);
		logic [15:0]          noise;
		logic [CFG_IDX_W-1:0] stray;
		noise = 16'($urandom);
		stray = CFG_IDX_W'($urandom_range(32'(REG_BYTES_PER_PIXEL) + 1, 255));
		write_register(REG_SCREEN_WIDTH, {noise[15:12], w});
		write_register(REG_SCREEN_HEIGHT, {noise[11:8], h});
		write_register(REG_BYTES_PER_LINE, {noise[7], bpl});
		write_register(REG_BYTES_PER_PIXEL, {noise[12:0], bpp});
		write_register(stray, noise);
	endtask

	task automatic queue_text(int count);
		int         r;
		logic [7:0] ch;
		repeat (count) begin
			r = $urandom_range(0, 199);
			if (r < 140)
				ch = 8'($urandom_range(8'h20, 8'h7E));
			else if (r < 155)
				ch = CH_LF;
			else if (r < 165)
				ch = CH_CR;
			else if (r < 175)
				ch = CH_TAB;
			else if (r < 183)
				ch = CH_BS;
			else if (r < 188)
				ch = CH_UP;
			else if (r < 189)
				ch = CH_FF;
			else
				ch = 8'($urandom_range(0, 255));
			char_backlog.push_back(ch);
		end
	endtask

	initial begin : stimulus
		int p;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		char_bus.valid = 1'b0;
		char_bus.char_code = '0;
		res_bus.ready = 1'b0;
		cur_x = LEFT_MARGIN;
		cur_y = TOP_MARGIN;
		scr_w = RST_SCREEN_WIDTH;
		scr_h = RST_SCREEN_HEIGHT;
		line_stride = RST_BYTES_PER_LINE;
		pix_bytes = RST_BYTES_PER_PIXEL;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		foreach (OPENING_TEXT[i])
			char_backlog.push_back(OPENING_TEXT[i]);
		wait_drained();
		set_screen(12'd80, 12'd48, 15'd1, 3'd1);
		foreach (NARROW_TEXT[i])
			char_backlog.push_back(NARROW_TEXT[i]);

		for (p = 0; p < 10; p++) begin
			wait_drained();
			case (p)
				0: set_screen(12'd4095, 12'd4095, 15'd32767, 3'd7);
				2, 7: set_screen(12'd80, 12'd48, 15'd1, 3'd1);
				3, 8: set_screen(12'($urandom_range(0, 95)), 12'($urandom_range(0, 63)),
					15'($urandom_range(0, 32767)), 3'($urandom_range(0, 7)));
				5: set_screen(RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, RST_BYTES_PER_LINE,
					RST_BYTES_PER_PIXEL);
				default: set_screen(12'($urandom_range(80, 4095)),
					12'($urandom_range(48, 4095)), 15'($urandom_range(1, 16384)),
					3'($urandom_range(1, 4)));
			endcase
			send_gaps_on = (p != 6) && (p != 3) && (p != 8);
			recv_stalls_on = (p != 6);
			if (p == 3 || p == 8)
				holds_asked++;
			queue_text(86);
			if (p == 3 || p == 8) begin
				wait_drained();
				send_gaps_on = 1'b1;
			end
			queue_text(86);
		end
		wait_drained();

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
